>>> rtl/rccf_pkg.sv
// package for the rgb color cycle fader with pwm
// holds function codes, color table, result type and field widths
// no dependencies
`default_nettype none

package rccf_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned StepW  = 4;
  localparam int unsigned HoldW  = 8;

  localparam logic [StepW-1:0]  LastStep  = 4'd8;
  localparam logic [StepW-1:0]  FirstStep = 4'd1;
  localparam logic [LevelW-1:0] PwmTop    = 8'd254;
  localparam logic [LevelW-1:0] Full      = 8'd255;

  // reset values of the config registers
  localparam logic [HoldW-1:0] HoldTicksRst    = 8'd90;
  localparam logic [StepW-1:0] LoopBackStepRst = 4'd4;

  // function codes carried in s_axis_tuser
  localparam logic [1:0] FUNC_PWM  = 2'd0;
  localparam logic [1:0] FUNC_FADE = 2'd1;
  localparam logic [1:0] FUNC_LOAD = 2'd2;
  localparam logic [1:0] FUNC_STOP = 2'd3;

  // config register indexes (paddr[2])
  localparam logic REG_HOLD_TICKS     = 1'b0;
  localparam logic REG_LOOP_BACK_STEP = 1'b1;

  typedef struct packed {
    logic [LevelW-1:0] blue;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [StepW-1:0] step_now;
    rgb_t             level;
    logic             blue_on;
    logic             green_on;
    logic             red_on;
  } result_t;

  // goal color of a step; valid for steps 1..8
  function automatic rgb_t goal_color(input logic [StepW-1:0] step);
    rgb_t c;
    c = '0;
    case (step)
      4'd1: c.red = Full;
      4'd2: begin
        c.red   = Full;
        c.green = Full;
      end
      4'd3: c.green = Full;
      4'd4: c.blue = Full;
      4'd5: begin
        c.red  = Full;
        c.blue = Full;
      end
      4'd6: c.red = Full;
      4'd7: begin
        c.red   = Full;
        c.green = Full;
      end
      4'd8: c.green = Full;
      default: c = '0;
    endcase
    return c;
  endfunction

  // one step of a level toward its goal
  function automatic logic [LevelW-1:0] toward(input logic [LevelW-1:0] v,
                                               input logic [LevelW-1:0] g);
    logic [LevelW-1:0] r;
    r = v;
    if (v > g) r = v - 8'd1;
    else if (v < g) r = v + 8'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rccf_cfg.sv
// apb config registers: hold_ticks and loop_back_step
// depends on rccf_pkg
`default_nettype none

module rccf_cfg
  import rccf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [HoldW-1:0] hold_ticks,
  output logic      [StepW-1:0] loop_back_step
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks     <= HoldTicksRst;
      loop_back_step <= LoopBackStepRst;
    end else if (wr_en) begin
      case (paddr[2])
        REG_HOLD_TICKS:     hold_ticks     <= pwdata[HoldW-1:0];
        REG_LOOP_BACK_STEP: loop_back_step <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HOLD_TICKS:     prdata = {{(32-HoldW){1'b0}}, hold_ticks};
      REG_LOOP_BACK_STEP: prdata = {{(32-StepW){1'b0}}, loop_back_step};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rccf_core.sv
// fader state and its update per item: pwm counter, levels, goals, step
// depends on rccf_pkg
`default_nettype none

module rccf_core
  import rccf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [1:0]       func,
  input  wire rgb_t             load,
  input  wire logic [HoldW-1:0] hold_ticks,
  input  wire logic [StepW-1:0] loop_back_step,
  output result_t               result
);

  rgb_t              level, level_next;
  rgb_t              goal, goal_next;
  logic [StepW-1:0]  color_index, color_index_next;
  logic [HoldW-1:0]  hold_count, hold_count_next;
  logic [LevelW-1:0] pwm_count, pwm_count_next;

  rgb_t              faded;
  rgb_t              table_goal;
  logic [StepW-1:0]  step_start;
  logic [StepW-1:0]  step_inc;
  logic [StepW-1:0]  back;
  logic              in_table;

  // fade tick helpers
  always_comb begin
    step_start = (color_index == '0) ? FirstStep : color_index;
    faded.red   = toward(level.red, goal.red);
    faded.green = toward(level.green, goal.green);
    faded.blue  = toward(level.blue, goal.blue);
    in_table    = (step_start >= FirstStep) && (step_start <= LastStep);
    table_goal  = in_table ? goal_color(step_start) : goal;
    step_inc    = step_start + 4'd1;
    // loop-back step clamped into 1..8
    if (loop_back_step == '0) back = FirstStep;
    else if (loop_back_step > LastStep) back = LastStep;
    else back = loop_back_step;
  end

  always_comb begin
    level_next       = level;
    goal_next        = goal;
    color_index_next = color_index;
    hold_count_next  = hold_count;
    pwm_count_next   = pwm_count;
    case (func)
      FUNC_PWM: begin
        pwm_count_next = (pwm_count >= PwmTop) ? '0 : pwm_count + 8'd1;
      end
      FUNC_FADE: begin
        level_next       = faded;
        color_index_next = step_start;
        if (hold_count != '0) begin
          hold_count_next = hold_count - 8'd1;
        end else begin
          goal_next = table_goal;
          if (faded == table_goal) begin
            if (step_inc > LastStep || step_inc == '0) color_index_next = back;
            else color_index_next = step_inc;
            hold_count_next = hold_ticks;
          end
        end
      end
      FUNC_LOAD: begin
        level_next = load;
      end
      FUNC_STOP: begin
        color_index_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= '0;
      goal        <= '0;
      color_index <= '0;
      hold_count  <= '0;
      pwm_count   <= '0;
    end else if (fire) begin
      level       <= level_next;
      goal        <= goal_next;
      color_index <= color_index_next;
      hold_count  <= hold_count_next;
      pwm_count   <= pwm_count_next;
    end
  end

  // on flags use the state before the item
  always_comb begin
    result.red_on   = level.red > pwm_count;
    result.green_on = level.green > pwm_count;
    result.blue_on  = level.blue > pwm_count;
    result.level    = level_next;
    result.step_now = color_index_next;
  end

endmodule

`default_nettype wire

>>> rtl/rgb_color_cycle_fader_pwm_core.sv
// top level of the rgb color cycle fader with three-channel pwm
// depends on rccf_pkg, rccf_cfg, rccf_core
//
// usage:
//   s_axis: one word per item; tuser carries the function code (pwm tick,
//   fade tick, load levels, stop cycle), tdata carries the three load levels.
//   m_axis: one word per item with the three pwm on flags, the three levels
//   after the item and the current color step (0 means stopped).
//   apb: hold_ticks at address 0, loop_back_step at address 4; write only
//   while no item is in flight.
// path: a word accepted on s_axis lands in the input register, is processed
//   once the result register is free and is then held in the result register for m_axis.
// throughput: one word per cycle while m_axis_tready is high; the state update
//   is a single pass of compares and increments between the input register and
//   the result register, so back-to-back words see each other's state.
// reset: synchronous rst clears levels, goals, step, hold count and pwm
//   counter, empties both registers and sets hold_ticks to 90 and
//   loop_back_step to 4.
// stall: when m_axis_tready is low the result register holds its word and
//   the input register fills; s_axis_tready drops only when both are full.
`default_nettype none

module rgb_color_cycle_fader_pwm_core
  import rccf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // load_red[7:0], load_green[15:8], load_blue[23:16]
  input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // red_on[0], green_on[1], blue_on[2],
                                          // red_level[10:3], green_level[18:11],
                                          // blue_level[26:19], step_now[30:27], zero[31]
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [HoldW-1:0] hold_ticks;
  logic [StepW-1:0] loop_back_step;

  // input register
  logic       in_valid;
  logic [1:0] in_func;
  rgb_t       in_load;

  // result register
  result_t    out_word;
  result_t    core_result;

  logic       out_free;
  logic       fire;

  rccf_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .hold_ticks     (hold_ticks),
    .loop_back_step (loop_back_step)
  );

  // result register can take a word when empty or being drained
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func <= s_axis_tuser;
      in_load <= s_axis_tdata;
    end
  end

  rccf_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .func           (in_func),
    .load           (in_load),
    .hold_ticks     (hold_ticks),
    .loop_back_step (loop_back_step),
    .result         (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= core_result;
    end
  end

  assign m_axis_tdata = {1'b0, out_word};

endmodule

`default_nettype wire

>>> verif/rgb_color_cycle_fader_pwm_core_tb.sv
// self-checking testbench for rgb_color_cycle_fader_pwm_core: streams items in,
// predicts every result word from a local model of the fader and compares it
// depends on rccf_pkg (types, function codes, register indexes) and the block rtl
module rgb_color_cycle_fader_pwm_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rccf_pkg::*;

  // clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // load_red[7:0], load_green[15:8], load_blue[23:16]
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // red_on[0], green_on[1], blue_on[2], red_level[10:3],
                               // green_level[18:11], blue_level[26:19], step_now[30:27]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the fader state and its two registers
  rgb_t        cur_level;
  rgb_t        cur_goal;
  logic [3:0]  cur_step;
  logic [7:0]  hold_left;
  logic [7:0]  pwm_cnt;
  logic [7:0]  hold_ticks_reg;
  logic [3:0]  loop_back_reg;

  // result words predicted but not yet seen on the output
  result_t     expected_words[$];

  // run bookkeeping
  int          fail_count = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          pwm_wraps = 0;
  logic [8:0]  steps_seen = '0;
  bit          idle_on = 1'b1;   // random gaps and stalls allowed
  int          rx_hold_left = 0; // long receiver hold-off, counted down by the receiver

  rgb_color_cycle_fader_pwm_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fader model
  // ---------------------------------------------------------------------------

  function automatic rgb_t mk_rgb(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    rgb_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  // target color of each step of the cycle; no entry outside 1..8
  function automatic rgb_t step_color(input logic [3:0] s);
    rgb_t c;
    c = '0;
    case (s)
      4'd1, 4'd6: c.red = Full;
      4'd2, 4'd7: begin
        c.red   = Full;
        c.green = Full;
      end
      4'd3, 4'd8: c.green = Full;
      4'd4: c.blue = Full;
      4'd5: begin
        c.red  = Full;
        c.blue = Full;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] step_toward(input logic [7:0] v, input logic [7:0] g);
    if (v > g) return v - 8'd1;
    if (v < g) return v + 8'd1;
    return v;
  endfunction

  // advances the local state by one item and returns the word the block must emit
  function automatic result_t predict_fader_word(input logic [1:0] fn, input rgb_t ld);
    result_t    r;
    logic [3:0] back;
    // on flags use the level and the counter from before this item
    r.red_on   = cur_level.red > pwm_cnt;
    r.green_on = cur_level.green > pwm_cnt;
    r.blue_on  = cur_level.blue > pwm_cnt;
    case (fn)
      FUNC_PWM: begin
        if (pwm_cnt >= PwmTop) begin
          pwm_cnt = '0;
          pwm_wraps++;
        end else begin
          pwm_cnt = pwm_cnt + 8'd1;
        end
      end
      FUNC_FADE: begin
        if (cur_step == 4'd0) cur_step = FirstStep;
        cur_level.red   = step_toward(cur_level.red, cur_goal.red);
        cur_level.green = step_toward(cur_level.green, cur_goal.green);
        cur_level.blue  = step_toward(cur_level.blue, cur_goal.blue);
        if (hold_left != 8'd0) begin
          hold_left = hold_left - 8'd1;
        end else begin
          if (cur_step >= FirstStep && cur_step <= LastStep) cur_goal = step_color(cur_step);
          if (cur_level == cur_goal) begin
            cur_step = cur_step + 4'd1;
            if (cur_step > LastStep || cur_step == 4'd0) begin
              // loop-back register is clamped into 1..8
              back = loop_back_reg;
              if (back == 4'd0) back = FirstStep;
              if (back > LastStep) back = LastStep;
              cur_step = back;
            end
            hold_left = hold_ticks_reg;
          end
        end
      end
      FUNC_LOAD: cur_level = ld;
      default: cur_step = '0;
    endcase
    r.level    = cur_level;
    r.step_now = cur_step;
    steps_seen[cur_step] = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // every word taken from the output is matched against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = m_axis_tdata[30:0];
      words_out++;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t ns: unexpected word, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_words.pop_front();
        check_field("red_on", 8'(want.red_on), 8'(got.red_on));
        check_field("green_on", 8'(want.green_on), 8'(got.green_on));
        check_field("blue_on", 8'(want.blue_on), 8'(got.blue_on));
        check_field("red_level", want.level.red, got.level.red);
        check_field("green_level", want.level.green, got.level.green);
        check_field("blue_level", want.level.blue, got.level.blue);
        check_field("step_now", 8'(want.step_now), 8'(got.step_now));
      end
    end
  end

  // receiver: random stall bursts while idling is on, plus the long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offers one word, waits for the handshake, then records the prediction
  task automatic send_word(input logic [1:0] fn, input rgb_t ld);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= ld;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    expected_words.push_back(predict_fader_word(fn, ld));
    words_in++;
  endtask

  function automatic rgb_t random_levels();
    logic [23:0] v;
    v = 24'($urandom);
    return v;
  endfunction

  // a level a few counts short of full or above zero
  function automatic logic [7:0] nudge(input logic [7:0] target);
    if (target == Full) return Full - 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 3));
  endfunction

  // levels close to the color the current step fades to
  function automatic rgb_t near_goal();
    rgb_t g;
    g = step_color(cur_step == 4'd0 ? FirstStep : cur_step);
    return mk_rgb(nudge(g.red), nudge(g.green), nudge(g.blue));
  endfunction

  // stop sender, let every predicted word come out, then cover the pipeline depth
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic idx, input logic [7:0] want_v);
    logic [7:0] got_v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got_v = (idx == REG_HOLD_TICKS) ? prdata[7:0] : {4'h0, prdata[3:0]};
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    check_field(idx == REG_HOLD_TICKS ? "hold_ticks read" : "loop_back_step read",
                want_v, got_v);
  endtask

  // registers only change once the block has gone quiet
  task automatic set_config(input logic [7:0] hold, input logic [3:0] loop_back);
    drain_results();
    apb_write(REG_HOLD_TICKS, ($urandom & 32'hFFFF_FF00) | hold);
    apb_write(REG_LOOP_BACK_STEP, ($urandom & 32'hFFFF_FFF0) | loop_back);
    hold_ticks_reg = hold;
    loop_back_reg  = loop_back;
    apb_read_check(REG_HOLD_TICKS, hold);
    apb_read_check(REG_LOOP_BACK_STEP, {4'h0, loop_back});
  endtask

  // random mix; stop_pct sets how much noise breaks the color cycle
  task automatic send_mixed(input int n, input int stop_pct);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < stop_pct) send_word(FUNC_STOP, random_levels());
      else if (pick < 40) send_word(FUNC_FADE, random_levels());
      else if (pick < 62) send_word(FUNC_PWM, random_levels());
      else if (pick < 80) send_word(FUNC_LOAD, near_goal());
      else send_word(FUNC_LOAD, random_levels());
    end
  endtask

  // well-formed walk: park the levels near the goal and fade until the step moves
  task automatic walk_colors(input int n_steps);
    logic [3:0] from;
    int         tries;
    repeat (n_steps) begin
      from = (cur_step == 4'd0) ? FirstStep : cur_step;
      send_word(FUNC_LOAD, near_goal());
      tries = 0;
      while ((cur_step == from || cur_step == 4'd0) && tries < 24) begin
        if ($urandom_range(0, 4) == 0) send_word(FUNC_PWM, random_levels());
        else send_word(FUNC_FADE, random_levels());
        tries++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_register_reset();
    apb_read_check(REG_HOLD_TICKS, HoldTicksRst);
    apb_read_check(REG_LOOP_BACK_STEP, {4'h0, LoopBackStepRst});
  endtask

  // level extremes, each function, restart from stop, goal met, pwm compare edges
  task automatic test_directed_corners();
    rgb_t probe;
    send_word(FUNC_PWM, mk_rgb(Full, Full, Full));      // load data ignored, all off
    send_word(FUNC_LOAD, mk_rgb(Full, Full, Full));
    send_word(FUNC_PWM, '0);                            // all on
    send_word(FUNC_LOAD, '0);
    send_word(FUNC_PWM, '0);
    send_word(FUNC_LOAD, mk_rgb(8'hAA, 8'h55, 8'hF0));
    send_word(FUNC_LOAD, mk_rgb(8'h55, 8'hAA, 8'h0F));
    send_word(FUNC_FADE, '0);                           // fade while stopped starts at red
    send_word(FUNC_LOAD, mk_rgb(Full, 8'h00, 8'h00));
    send_word(FUNC_FADE, '0);                           // goal met, step advances, hold loads
    send_word(FUNC_FADE, '0);                           // holding
    send_word(FUNC_STOP, '0);
    send_word(FUNC_STOP, mk_rgb(Full, Full, Full));     // stop while already stopped
    send_word(FUNC_FADE, mk_rgb(Full, Full, Full));     // restart during hold
    // levels just above, at and below the counter
    probe = mk_rgb(pwm_cnt + 8'd1, pwm_cnt, pwm_cnt - 8'd1);
    send_word(FUNC_LOAD, probe);
    send_word(FUNC_PWM, '0);
    send_word(FUNC_PWM, '0);
    send_word(FUNC_LOAD, mk_rgb(8'h80, 8'h7F, 8'h01));
    send_word(FUNC_FADE, random_levels());
  endtask

  // full color cycle with wrap to each kind of loop-back setting
  task automatic test_color_walks();
    set_config(8'd0, 4'd1);
    walk_colors(12);
    set_config(8'd3, 4'd0);                             // zero loop-back taken as step one
    walk_colors(12);
    set_config(8'd2, 4'd15);                            // out of range loop-back taken as eight
    walk_colors(10);
    send_mixed(20, 2);
  endtask

  // longest hold, with enough pwm ticks to wrap the counter
  task automatic test_long_hold_and_pwm_wrap();
    int pick;
    set_config(8'd255, 4'd9);
    walk_colors(1);
    repeat (560) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) send_word(FUNC_FADE, random_levels());
      else if (pick < 96) send_word(FUNC_PWM, random_levels());
      else send_word(FUNC_LOAD, random_levels());
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    set_config(8'd1, 4'd6);
    idle_on = 1'b0;
    rx_hold_left = 80;
    send_mixed(60, 3);
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    set_config(8'd1, 4'd7);
    walk_colors(6);
    send_mixed(200, 4);
  endtask

  // back-to-back words with no gaps or stalls at all
  task automatic test_full_rate();
    set_config(8'd0, 4'd8);
    idle_on = 1'b0;
    walk_colors(10);
    send_mixed(80, 2);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_PWM;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cur_level      = '0;
    cur_goal       = '0;
    cur_step       = '0;
    hold_left      = '0;
    pwm_cnt        = '0;
    hold_ticks_reg = HoldTicksRst;
    loop_back_reg  = LoopBackStepRst;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_directed_corners();
    test_color_walks();
    test_long_hold_and_pwm_wrap();
    test_output_backpressure();
    test_random_mix();
    test_full_rate();

    drain_results();
    repeat (8) @(posedge clk);
    $display("run covered %0d words in, %0d words out, %0d pwm counter wraps",
             words_in, words_out, pwm_wraps);
    $display("color steps reached (bit per step, 0 = stopped): %b; hold 0..255, loop-back 0..15",
             steps_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #1_000_000;
    $display("timeout with %0d words still expected", expected_words.size());
    $display("FAILURE");
    $finish;
  end

endmodule
